// File: rtl/grid_map_text_parser_top_assert.svh
// Assertion macros used by the grid map text parser RTL.
`ifndef GRID_MAP_TEXT_PARSER_TOP_ASSERT_SVH
`define GRID_MAP_TEXT_PARSER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define GMTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define GMTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/gmtp_pkg.sv
// Shared types, constants and helper functions of the grid map text parser.
package gmtp_pkg;

  localparam int unsigned MAX_VALUE_DEF = 255;
  localparam int unsigned FIFO_DEPTH    = 4;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_CELL   = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  // Cell kinds
  localparam logic [1:0] CELL_WHITE = 2'd0;
  localparam logic [1:0] CELL_BLACK = 2'd1;
  localparam logic [1:0] CELL_WALL  = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd1;
  localparam logic [2:0] ERR_NEED_DIG  = 3'd2;
  localparam logic [2:0] ERR_NEED_SEP  = 3'd3;
  localparam logic [2:0] ERR_NEED_CELL = 3'd4;
  localparam logic [2:0] ERR_NEED_END  = 3'd5;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd6;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef enum logic [2:0] {
    CLS_DIGIT = 3'd0,
    CLS_SEP   = 3'd1,
    CLS_WHITE = 3'd2,
    CLS_BLACK = 3'd3,
    CLS_WALL  = 3'd4,
    CLS_WS    = 3'd5,
    CLS_EOF   = 3'd6,
    CLS_BAD   = 3'd7
  } char_class_t;

  typedef enum logic [13:0] {
    PH_W_START  = 14'h0001,
    PH_W_DIG    = 14'h0002,
    PH_W_SEP    = 14'h0004,
    PH_H_START  = 14'h0008,
    PH_H_DIG    = 14'h0010,
    PH_RC_START = 14'h0020,
    PH_RC_DIG   = 14'h0040,
    PH_RC_SEP   = 14'h0080,
    PH_RR_START = 14'h0100,
    PH_RR_DIG   = 14'h0200,
    PH_CELLS    = 14'h0400,
    PH_TAIL     = 14'h0800,
    PH_DONE     = 14'h1000,
    PH_ERR      = 14'h2000
  } phase_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] grid_width;
    logic [7:0] grid_height;
    logic [7:0] robot_column;
    logic [7:0] robot_row;
    logic [7:0] cell_column;
    logic [7:0] cell_row;
    logic [1:0] cell_kind;
    logic [2:0] error_code;
    logic       last_of_run;
  } result_t;

  // Up to two results per byte: a header, then the result of the byte itself.
  typedef struct packed {
    logic    hdr_valid;
    result_t hdr;
    logic    res_valid;
    result_t res;
  } push_t;

  function automatic char_class_t classify(input logic [7:0] b, input logic eoi);
    char_class_t c;
    c = CLS_BAD;
    if (eoi || b == CH_NUL) begin
      c = CLS_EOF;
    end else if (b >= CH_ZERO && b <= CH_NINE) begin
      c = CLS_DIGIT;
    end else begin
      case (b)
        CH_SPACE, CH_LF: c = CLS_WS;
        CH_SEMI:         c = CLS_SEP;
        CH_O:            c = CLS_WHITE;
        CH_X:            c = CLS_BLACK;
        CH_STAR:         c = CLS_WALL;
        default:         c = CLS_BAD;
      endcase
    end
    return c;
  endfunction

  function automatic logic [1:0] cell_kind_of(input char_class_t c);
    logic [1:0] k;
    case (c)
      CLS_WHITE: k = CELL_WHITE;
      CLS_BLACK: k = CELL_BLACK;
      default:   k = CELL_WALL;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/gmtp_parser.sv
// Parser state machine: one classified byte per step, up to two results out.
`include "grid_map_text_parser_top_assert.svh"

module gmtp_parser #(
  parameter int unsigned MAX_VALUE = gmtp_pkg::MAX_VALUE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  gmtp_pkg::char_class_t cls,
  input  logic [3:0]            digit,
  output gmtp_pkg::push_t       push
);

  localparam int unsigned AW = $clog2(MAX_VALUE + 1);

  gmtp_pkg::phase_t ph, ph_next;
  logic [AW-1:0]    acc, acc_next;
  logic [AW-1:0]    saved_w, saved_w_next;
  logic [AW-1:0]    saved_h, saved_h_next;
  logic [AW-1:0]    saved_rc, saved_rc_next;
  logic [AW-1:0]    col, col_next;
  logic [AW-1:0]    row, row_next;
  logic [2:0]       err, err_next;

  logic [AW+3:0]    acc_x10;
  logic             ovf;
  logic [AW-1:0]    col_base, row_base;
  logic [AW:0]      col_inc, row_inc;
  logic             wrap, row_end;

  logic             fail, do_cell, do_done;
  logic [2:0]       fail_code;
  gmtp_pkg::result_t hdr, res;
  logic             hdr_v, res_v;

  assign acc_x10 = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (AW+4)'(digit);
  assign ovf     = acc_x10 > (AW+4)'(MAX_VALUE);

  // The first cell of the grid may arrive with the robot row terminator.
  assign col_base = (ph == gmtp_pkg::PH_RR_DIG) ? '0 : col;
  assign row_base = (ph == gmtp_pkg::PH_RR_DIG) ? '0 : row;
  assign col_inc  = {1'b0, col_base} + (AW+1)'(1);
  assign row_inc  = {1'b0, row_base} + (AW+1)'(1);
  assign wrap     = col_inc >= {1'b0, saved_w};
  assign row_end  = row_inc >= {1'b0, saved_h};

  always_comb begin
    ph_next       = ph;
    acc_next      = acc;
    saved_w_next  = saved_w;
    saved_h_next  = saved_h;
    saved_rc_next = saved_rc;
    col_next      = col;
    row_next      = row;
    err_next      = err;
    fail          = 1'b0;
    fail_code     = gmtp_pkg::ERR_NONE;
    do_cell       = 1'b0;
    do_done       = 1'b0;
    hdr           = '0;
    res           = '0;
    hdr_v         = 1'b0;
    res_v         = 1'b0;

    case (ph)
      gmtp_pkg::PH_ERR: begin
        res_v            = 1'b1;
        res.result_kind  = gmtp_pkg::KIND_ERROR;
        res.error_code   = err;
      end
      gmtp_pkg::PH_DONE: begin
      end
      default: begin
        if (cls == gmtp_pkg::CLS_BAD) begin
          fail      = 1'b1;
          fail_code = gmtp_pkg::ERR_BAD_CHAR;
        end else begin
          case (ph)
            gmtp_pkg::PH_W_START, gmtp_pkg::PH_H_START,
            gmtp_pkg::PH_RC_START, gmtp_pkg::PH_RR_START: begin
              if (cls == gmtp_pkg::CLS_DIGIT) begin
                acc_next = AW'(digit);
                case (ph)
                  gmtp_pkg::PH_W_START:  ph_next = gmtp_pkg::PH_W_DIG;
                  gmtp_pkg::PH_H_START:  ph_next = gmtp_pkg::PH_H_DIG;
                  gmtp_pkg::PH_RC_START: ph_next = gmtp_pkg::PH_RC_DIG;
                  default:               ph_next = gmtp_pkg::PH_RR_DIG;
                endcase
              end else if (cls != gmtp_pkg::CLS_WS) begin
                fail      = 1'b1;
                fail_code = gmtp_pkg::ERR_NEED_DIG;
              end
            end
            gmtp_pkg::PH_W_SEP, gmtp_pkg::PH_RC_SEP: begin
              if (cls == gmtp_pkg::CLS_SEP) begin
                ph_next = (ph == gmtp_pkg::PH_W_SEP) ? gmtp_pkg::PH_H_START
                                                     : gmtp_pkg::PH_RR_START;
              end else if (cls != gmtp_pkg::CLS_WS) begin
                fail      = 1'b1;
                fail_code = gmtp_pkg::ERR_NEED_SEP;
              end
            end
            gmtp_pkg::PH_W_DIG, gmtp_pkg::PH_H_DIG,
            gmtp_pkg::PH_RC_DIG, gmtp_pkg::PH_RR_DIG: begin
              if (cls == gmtp_pkg::CLS_DIGIT) begin
                if (ovf) begin
                  fail      = 1'b1;
                  fail_code = gmtp_pkg::ERR_TOO_LARGE;
                end else begin
                  acc_next = acc_x10[AW-1:0];
                end
              end else begin
                // Close the number, then hand the same byte to the next phase.
                case (ph)
                  gmtp_pkg::PH_W_DIG: begin
                    saved_w_next = acc;
                    if (cls == gmtp_pkg::CLS_SEP) begin
                      ph_next = gmtp_pkg::PH_H_START;
                    end else if (cls == gmtp_pkg::CLS_WS) begin
                      ph_next = gmtp_pkg::PH_W_SEP;
                    end else begin
                      fail      = 1'b1;
                      fail_code = gmtp_pkg::ERR_NEED_SEP;
                    end
                  end
                  gmtp_pkg::PH_H_DIG: begin
                    saved_h_next = acc;
                    if (cls == gmtp_pkg::CLS_WS) begin
                      ph_next = gmtp_pkg::PH_RC_START;
                    end else begin
                      fail      = 1'b1;
                      fail_code = gmtp_pkg::ERR_NEED_DIG;
                    end
                  end
                  gmtp_pkg::PH_RC_DIG: begin
                    saved_rc_next = acc;
                    if (cls == gmtp_pkg::CLS_SEP) begin
                      ph_next = gmtp_pkg::PH_RR_START;
                    end else if (cls == gmtp_pkg::CLS_WS) begin
                      ph_next = gmtp_pkg::PH_RC_SEP;
                    end else begin
                      fail      = 1'b1;
                      fail_code = gmtp_pkg::ERR_NEED_SEP;
                    end
                  end
                  default: begin
                    hdr_v            = 1'b1;
                    hdr.result_kind  = gmtp_pkg::KIND_HEADER;
                    hdr.grid_width   = 8'(saved_w);
                    hdr.grid_height  = 8'(saved_h);
                    hdr.robot_column = 8'(saved_rc);
                    hdr.robot_row    = 8'(acc);
                    col_next         = '0;
                    row_next         = '0;
                    if (saved_w == '0 || saved_h == '0) begin
                      ph_next = gmtp_pkg::PH_TAIL;
                      if (cls == gmtp_pkg::CLS_EOF) begin
                        do_done = 1'b1;
                      end else if (cls != gmtp_pkg::CLS_WS) begin
                        fail      = 1'b1;
                        fail_code = gmtp_pkg::ERR_NEED_END;
                      end
                    end else begin
                      ph_next = gmtp_pkg::PH_CELLS;
                      if (cls == gmtp_pkg::CLS_WHITE || cls == gmtp_pkg::CLS_BLACK ||
                          cls == gmtp_pkg::CLS_WALL) begin
                        do_cell = 1'b1;
                      end else if (cls != gmtp_pkg::CLS_WS) begin
                        fail      = 1'b1;
                        fail_code = gmtp_pkg::ERR_NEED_CELL;
                      end
                    end
                  end
                endcase
              end
            end
            gmtp_pkg::PH_CELLS: begin
              if (cls == gmtp_pkg::CLS_WHITE || cls == gmtp_pkg::CLS_BLACK ||
                  cls == gmtp_pkg::CLS_WALL) begin
                do_cell = 1'b1;
              end else if (cls != gmtp_pkg::CLS_WS) begin
                fail      = 1'b1;
                fail_code = gmtp_pkg::ERR_NEED_CELL;
              end
            end
            gmtp_pkg::PH_TAIL: begin
              if (cls == gmtp_pkg::CLS_EOF) begin
                do_done = 1'b1;
              end else if (cls != gmtp_pkg::CLS_WS) begin
                fail      = 1'b1;
                fail_code = gmtp_pkg::ERR_NEED_END;
              end
            end
            default: begin
            end
          endcase
        end
      end
    endcase

    if (do_cell) begin
      res_v           = 1'b1;
      res.result_kind = gmtp_pkg::KIND_CELL;
      res.cell_column = 8'(col_base);
      res.cell_row    = 8'(row_base);
      res.cell_kind   = gmtp_pkg::cell_kind_of(cls);
      if (wrap) begin
        col_next = '0;
        row_next = row_inc[AW-1:0];
        if (row_end) begin
          ph_next = gmtp_pkg::PH_TAIL;
        end
      end else begin
        col_next = col_inc[AW-1:0];
        row_next = row_base;
      end
    end

    if (do_done) begin
      res_v           = 1'b1;
      res.result_kind = gmtp_pkg::KIND_DONE;
      ph_next         = gmtp_pkg::PH_DONE;
    end

    if (fail) begin
      res_v           = 1'b1;
      res.result_kind = gmtp_pkg::KIND_ERROR;
      res.error_code  = fail_code;
      err_next        = fail_code;
      ph_next         = gmtp_pkg::PH_ERR;
    end

    res.last_of_run = res_v;
    hdr.last_of_run = ~res_v;
  end

  assign push.hdr_valid = step & hdr_v;
  assign push.hdr       = hdr;
  assign push.res_valid = step & res_v;
  assign push.res       = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph       <= gmtp_pkg::PH_W_START;
      acc      <= '0;
      saved_w  <= '0;
      saved_h  <= '0;
      saved_rc <= '0;
      col      <= '0;
      row      <= '0;
      err      <= gmtp_pkg::ERR_NONE;
    end else if (step) begin
      ph       <= ph_next;
      acc      <= acc_next;
      saved_w  <= saved_w_next;
      saved_h  <= saved_h_next;
      saved_rc <= saved_rc_next;
      col      <= col_next;
      row      <= row_next;
      err      <= err_next;
    end
  end

  `GMTP_ASSERT_ALWAYS(a_err_sticky, (ph == gmtp_pkg::PH_ERR) |-> (err != gmtp_pkg::ERR_NONE), "error phase without code")
  `GMTP_ASSERT(a_hdr_only_rr, push.hdr_valid |-> (ph == gmtp_pkg::PH_RR_DIG), "header outside robot row")
  `GMTP_ASSERT(a_done_silent, (step && ph == gmtp_pkg::PH_DONE) |=> (ph == gmtp_pkg::PH_DONE), "left done")
  `GMTP_ASSERT(a_err_repeats, (step && ph == gmtp_pkg::PH_ERR) |-> (push.res_valid && push.res.result_kind == gmtp_pkg::KIND_ERROR), "no error after error")

endmodule

// File: rtl/gmtp_result_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
module gmtp_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  gmtp_pkg::push_t   push,
  input  logic              out_stall,
  output logic              out_valid,
  output gmtp_pkg::result_t head,
  output logic              room
);

  localparam int unsigned DEPTH = gmtp_pkg::FIFO_DEPTH;
  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  gmtp_pkg::result_t entries [DEPTH];
  logic [PW-1:0]     wr_ptr, rd_ptr;
  logic [CW-1:0]     count;
  logic [1:0]        n_push;
  logic              pop;
  gmtp_pkg::result_t w0;

  assign n_push    = {1'b0, push.hdr_valid} + {1'b0, push.res_valid};
  assign pop       = out_valid & ~out_stall;
  assign out_valid = count != '0;
  assign head      = entries[rd_ptr];
  // Leave space for the worst case of two entries per byte.
  assign room      = count <= CW'(DEPTH - 2);
  assign w0        = push.hdr_valid ? push.hdr : push.res;

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      entries[wr_ptr] <= w0;
    end
    if (n_push == 2'd2) begin
      entries[wr_ptr + PW'(1)] <= push.res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(n_push);
      rd_ptr <= rd_ptr + PW'(pop);
      count  <= count + CW'(n_push) - CW'(pop);
    end
  end

endmodule

// File: rtl/grid_map_text_parser_top.sv
// Top level of the grid map text parser: input register, parser and result queue.
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   input   | in_valid, in_stall, data_byte, end_of_input    | in
//   result  | out_valid, out_stall, result_kind .. last_of_run | out
//
// One byte per cycle while in_stall is low: a byte is held in the input register
// and parsed into the four-entry result queue once the queue has room.
// Each byte yields at most one result, except the robot row terminator, which
// can yield two; the queue drains one result per cycle while out_stall is low.
// in_stall rises only when the queue holds more than two results.
// rst clears all control state synchronously; no clearing pass.
module grid_map_text_parser_top #(
  parameter int unsigned MAX_VALUE = gmtp_pkg::MAX_VALUE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] result_kind,
  output logic [7:0] grid_width,
  output logic [7:0] grid_height,
  output logic [7:0] robot_column,
  output logic [7:0] robot_row,
  output logic [7:0] cell_column,
  output logic [7:0] cell_row,
  output logic [1:0] cell_kind,
  output logic [2:0] error_code,
  output logic       last_of_run
);

  logic              in_full;
  logic [7:0]        in_byte;
  logic              in_eoi;
  logic              room;
  logic              step;
  gmtp_pkg::push_t   push;
  gmtp_pkg::result_t head;

  assign step     = in_full & room;
  assign in_stall = in_full & ~room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  // Hold the byte until the parser takes it.
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= data_byte;
      in_eoi  <= end_of_input;
    end
  end

  gmtp_parser #(
    .MAX_VALUE(MAX_VALUE)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cls  (gmtp_pkg::classify(in_byte, in_eoi)),
    .digit(4'(in_byte - gmtp_pkg::CH_ZERO)),
    .push (push)
  );

  gmtp_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .head     (head),
    .room     (room)
  );

  assign result_kind  = head.result_kind;
  assign grid_width   = head.grid_width;
  assign grid_height  = head.grid_height;
  assign robot_column = head.robot_column;
  assign robot_row    = head.robot_row;
  assign cell_column  = head.cell_column;
  assign cell_row     = head.cell_row;
  assign cell_kind    = head.cell_kind;
  assign error_code   = head.error_code;
  assign last_of_run  = head.last_of_run;

endmodule
